[rtl/kdes_pkg.sv]
package kdes_pkg;

  // Number of buttons served by the scanner (1 to 4).
  localparam int BUTTON_NUM = 4;
  localparam int BtnIdxW = (BUTTON_NUM > 1) ? $clog2(BUTTON_NUM) : 1;

  localparam int HoldW = 16;
  localparam int EventW = 8;
  localparam int LevelsW = 4;

  // Configuration register indexes.
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS_TICKS = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ACTIVE_LEVELS = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BUTTON_MODES = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SHORT_EVENT_IDS = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LONG_EVENT_IDS = 3'd4;

  // Per-button debounce phase.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_PRESSED = 2'd2,
    PH_WAIT = 2'd3
  } phase_t;

  // Per-button reporting mode.
  typedef enum logic [1:0] {
    MODE_RELEASE = 2'd0,
    MODE_PRESS = 2'd1,
    MODE_LONG = 2'd2,
    MODE_INACTIVE = 2'd3
  } mode_t;

  // Scan sequencer state.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } scan_state_t;

  // What the shared update unit sees of one button.
  typedef struct packed {
    phase_t phase;
    logic [HoldW-1:0] hold;
    mode_t mode;
    logic pressed;
    logic [EventW-1:0] short_id;
    logic [EventW-1:0] long_id;
    logic [HoldW-1:0] long_ticks;
  } btn_in_t;

  // Updated button state and the event it raises.
  typedef struct packed {
    phase_t phase;
    logic [HoldW-1:0] hold;
    logic [EventW-1:0] ev;
  } btn_out_t;

endpackage

[rtl/kdes_button_unit.sv]
module kdes_button_unit
  import kdes_pkg::*;
(
  input  btn_in_t  btn_in,
  output btn_out_t btn_out
);

  logic [HoldW-1:0] hold_inc;

  // Saturating held-tick count.
  assign hold_inc = (btn_in.hold != {HoldW{1'b1}}) ? btn_in.hold + 1'b1 : btn_in.hold;

  // One step of the debounce machine for the selected button.
  always_comb begin
    btn_out.phase = btn_in.phase;
    btn_out.hold = btn_in.hold;
    btn_out.ev = '0;
    if (btn_in.mode != MODE_INACTIVE) begin
      case (btn_in.phase)
        PH_IDLE: begin
          if (btn_in.pressed) begin
            btn_out.phase = PH_DEBOUNCE;
            btn_out.hold = '0;
          end
        end
        PH_DEBOUNCE: begin
          if (btn_in.pressed) begin
            btn_out.phase = PH_PRESSED;
            if (btn_in.mode == MODE_PRESS) begin
              btn_out.ev = btn_in.short_id;
            end
          end else begin
            btn_out.phase = PH_IDLE;
          end
        end
        PH_PRESSED: begin
          if (btn_in.pressed) begin
            if (btn_in.mode == MODE_LONG) begin
              btn_out.hold = hold_inc;
              if (hold_inc >= btn_in.long_ticks) begin
                btn_out.ev = btn_in.long_id;
                btn_out.phase = PH_WAIT;
              end
            end
          end else begin
            if (btn_in.mode == MODE_RELEASE || btn_in.mode == MODE_LONG) begin
              btn_out.ev = btn_in.short_id;
            end
            btn_out.phase = PH_IDLE;
          end
        end
        default: begin
          if (!btn_in.pressed) begin
            btn_out.phase = PH_IDLE;
          end
        end
      endcase
    end
  end

endmodule

[rtl/key_debounce_event_scanner_core.sv]
// Channel   Direction  Payload (lowest bits first)
// s_axis    in         tdata[3:0] button_levels, tdata[7:4] zero
// m_axis    out        tdata[7:0] event_code
// cfg       in         cfg_index register index, cfg_data write value
//
// A scan request is taken in the idle state; one button is then updated per
// cycle by the shared button unit. The scan ends at the first nonzero event or
// after the last button. The event sits in an output register, so a new
// request is taken while it waits; a finishing scan stalls only while that
// register is still full. Reset returns every button to idle with a zero count.
module key_debounce_event_scanner_core
  import kdes_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [3:0] button_levels
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [7:0] event_code
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [31:0]         cfg_data
);

  logic [HoldW-1:0] long_press_ticks;
  logic [3:0] active_levels;
  logic [7:0] button_modes;
  logic [31:0] short_event_ids;
  logic [31:0] long_event_ids;

  phase_t button_phase [BUTTON_NUM];
  logic [HoldW-1:0] hold_ticks [BUTTON_NUM];

  scan_state_t state, state_next;
  logic [BtnIdxW-1:0] idx;
  logic [LevelsW-1:0] levels;

  btn_in_t btn_in;
  btn_out_t btn_out;

  logic out_free;
  logic scan_last;
  logic step;
  logic finish;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= 16'd100;
      active_levels <= '0;
      button_modes <= 8'hFF;
      short_event_ids <= '0;
      long_event_ids <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LONG_PRESS_TICKS: long_press_ticks <= cfg_data[HoldW-1:0];
        REG_ACTIVE_LEVELS: active_levels <= cfg_data[3:0];
        REG_BUTTON_MODES: button_modes <= cfg_data[7:0];
        REG_SHORT_EVENT_IDS: short_event_ids <= cfg_data;
        REG_LONG_EVENT_IDS: long_event_ids <= cfg_data;
        default: ;
      endcase
    end
  end

  // Operands for the button currently visited.
  always_comb begin
    btn_in.phase = button_phase[idx];
    btn_in.hold = hold_ticks[idx];
    btn_in.mode = mode_t'(button_modes[2*idx +: 2]);
    btn_in.pressed = (levels[idx] == active_levels[idx]);
    btn_in.short_id = short_event_ids[8*idx +: 8];
    btn_in.long_id = long_event_ids[8*idx +: 8];
    btn_in.long_ticks = long_press_ticks;
  end

  kdes_button_unit u_button (
    .btn_in  (btn_in),
    .btn_out (btn_out)
  );

  // Sequencer control.
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign scan_last = (btn_out.ev != '0) || (idx == BtnIdxW'(BUTTON_NUM - 1));

  always_comb begin
    state_next = state;
    s_axis_tready = 1'b0;
    step = 1'b0;
    finish = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!scan_last) begin
          step = 1'b1;
        end else if (out_free) begin
          step = 1'b1;
          finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Button index and sampled levels.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      idx <= '0;
    end else if (step && !finish) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      levels <= s_axis_tdata[LevelsW-1:0];
    end
  end

  // Per-button state write-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUTTON_NUM; i++) begin
        button_phase[i] <= PH_IDLE;
        hold_ticks[i] <= '0;
      end
    end else if (step) begin
      button_phase[idx] <= btn_out.phase;
      hold_ticks[idx] <= btn_out.hold;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_axis_tdata <= btn_out.ev;
    end
  end

endmodule

[test/kdes_event_checker.sv]
module kdes_event_checker
  import kdes_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [3:0] button_levels, [7:4] zero
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [7:0]         m_axis_tdata,   // [7:0] event_code
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the configuration registers.
  logic [HoldW-1:0]   long_ticks;
  logic [LevelsW-1:0] active_lv;
  logic [7:0]         modes;
  logic [31:0]        short_ids;
  logic [31:0]        long_ids;

  // Shadow copy of the per-button debounce machines.
  phase_t           btn_phase [BUTTON_NUM];
  logic [HoldW-1:0] btn_hold  [BUTTON_NUM];

  // Event codes predicted for accepted requests, oldest first.
  logic [EventW-1:0] expected_events [$];

  // Advance every visited button by one scan tick and return the event code.
  // Scanning stops at the first button that raises a nonzero code.
  function automatic logic [EventW-1:0] scan_tick(input logic [LevelsW-1:0] levels);
    mode_t             mode;
    logic              pressed;
    logic [EventW-1:0] ev;
    ev = '0;
    for (int b = 0; b < BUTTON_NUM && ev == '0; b++) begin
      mode    = mode_t'(modes[2*b +: 2]);
      pressed = (levels[b] == active_lv[b]);
      if (mode != MODE_INACTIVE) begin
        case (btn_phase[b])
          PH_IDLE: begin
            if (pressed) begin
              btn_phase[b] = PH_DEBOUNCE;
              btn_hold[b]  = '0;
            end
          end
          PH_DEBOUNCE: begin
            if (pressed) begin
              btn_phase[b] = PH_PRESSED;
              if (mode == MODE_PRESS) ev = short_ids[8*b +: 8];
            end else begin
              btn_phase[b] = PH_IDLE;
            end
          end
          PH_PRESSED: begin
            if (pressed) begin
              // Only long-press buttons count held ticks; the count saturates.
              if (mode == MODE_LONG) begin
                if (btn_hold[b] != '1) btn_hold[b] = btn_hold[b] + 1'b1;
                if (btn_hold[b] >= long_ticks) begin
                  ev           = long_ids[8*b +: 8];
                  btn_phase[b] = PH_WAIT;
                end
              end
            end else begin
              if (mode == MODE_RELEASE || mode == MODE_LONG) ev = short_ids[8*b +: 8];
              btn_phase[b] = PH_IDLE;
            end
          end
          default: begin
            if (!pressed) btn_phase[b] = PH_IDLE;
          end
        endcase
      end
    end
    return ev;
  endfunction

  // Observe all three channels at the rising edge.
  always @(posedge clk) begin
    logic [EventW-1:0] want;
    if (rst) begin
      long_ticks = 16'd100;
      active_lv  = '0;
      modes      = 8'hFF;
      short_ids  = '0;
      long_ids   = '0;
      for (int b = 0; b < BUTTON_NUM; b++) begin
        btn_phase[b] = PH_IDLE;
        btn_hold[b]  = '0;
      end
      expected_events.delete();
      fail_count = 0;
    end else begin
      // Register writes land before any request of the same edge is scanned.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LONG_PRESS_TICKS: long_ticks = cfg_data[HoldW-1:0];
          REG_ACTIVE_LEVELS:    active_lv  = cfg_data[LevelsW-1:0];
          REG_BUTTON_MODES:     modes      = cfg_data[7:0];
          REG_SHORT_EVENT_IDS:  short_ids  = cfg_data;
          REG_LONG_EVENT_IDS:   long_ids   = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_events.push_back(scan_tick(s_axis_tdata[LevelsW-1:0]));
      // Compare each delivered event with the oldest prediction.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_events.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected event %02h with no request outstanding", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          if (m_axis_tdata != want) begin
            if (fail_count < 10)
              $display("event mismatch: expected %02h, got %02h", want, m_axis_tdata);
            fail_count++;
          end
        end
      end
    end
    pending = expected_events.size();
  end

endmodule

[test/tb.sv]
module tb
  import kdes_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 1000;
  localparam int HoldOffCycles = 80;
  localparam int IdlePct       = 17;
  localparam int NoisePct      = 15;
  localparam int RandomPhases  = 8;
  localparam int PhaseItems    = 170;
  localparam int LongHoldTicks = 40;

  // Pressed-button masks for the directed part: glitch, release mode, press
  // mode, long press reaching its event, long press released early, two
  // buttons competing for one tick, an inactive button, and all pressed.
  localparam logic [LevelsW-1:0] DirectedMasks [24] = '{
    4'h1, 4'h0,
    4'h1, 4'h1, 4'h0,
    4'h2, 4'h2, 4'h0,
    4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h0,
    4'h4, 4'h4, 4'h4, 4'h0,
    4'h3, 4'h3, 4'h0, 4'h0,
    4'h8, 4'hF
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata = '0;   // [3:0] button_levels, [7:4] zero
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [7:0]         m_axis_tdata;        // [7:0] event_code
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  int fail_count;
  int pending;

  // Stimulus controls shared with the receiver process.
  bit no_idle  = 1'b0;
  bit hold_req = 1'b0;

  // Level that means pressed, as last written, and the per-button press model
  // used to build well-formed press and release runs.
  logic [LevelsW-1:0] cur_active = '0;
  bit held     [BUTTON_NUM];
  int run_left [BUTTON_NUM];

  always #2 clk = ~clk;

  key_debounce_event_scanner_core dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  kdes_event_checker chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // One register write; valid stays high so back-to-back writes need no gap.
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Write every register, with random bits above the tick, level and mode fields,
  // plus one write to an unused index that must be ignored.
  task automatic configure(input logic [HoldW-1:0] lp, input logic [LevelsW-1:0] act,
                           input logic [7:0] md, input logic [31:0] sid,
                           input logic [31:0] lid);
    logic [31:0] junk;
    junk = $urandom();
    cfg_write(REG_LONG_PRESS_TICKS, {junk[31:HoldW], lp});
    junk = $urandom();
    cfg_write(REG_ACTIVE_LEVELS, {junk[31:LevelsW], act});
    junk = $urandom();
    cfg_write(REG_BUTTON_MODES, {junk[31:8], md});
    cfg_write(REG_SHORT_EVENT_IDS, sid);
    cfg_write(REG_LONG_EVENT_IDS, lid);
    cfg_write(CfgIdxW'($urandom_range(REG_LONG_EVENT_IDS + 1, (1 << CfgIdxW) - 1)),
              $urandom());
    cfg_valid  <= 1'b0;
    cur_active = act;
    @(negedge clk);
  endtask

  // Offer one scan request, with a random gap in front unless idling is off.
  task automatic send_levels(input logic [LevelsW-1:0] levels);
    while (!no_idle && $urandom_range(0, 99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tdata  <= {{(8 - LevelsW){1'b0}}, levels};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Turn a mask of pressed buttons into raw pin levels.
  task automatic press(input logic [LevelsW-1:0] mask);
    send_levels(~(mask ^ cur_active));
  endtask

  // Stop offering and wait until every predicted event has been delivered.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] random_ids();
    logic [31:0] ids;
    for (int k = 0; k < 4; k++)
      ids[8*k +: 8] = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
    return ids;
  endfunction

  // Mostly press and release runs per button, some short enough to bounce,
  // some long enough to reach the long event; the rest is raw noise.
  task automatic random_phase(input int n_items, input int lp, input int hold_at,
                              input int pause_at);
    logic [LevelsW-1:0] mask;
    int                 run_max;
    run_max = (lp + 4 > 40) ? 40 : lp + 4;
    for (int i = 0; i < n_items; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (i == pause_at) drain();
      mask = '0;
      for (int b = 0; b < BUTTON_NUM; b++) begin
        if (run_left[b] == 0) begin
          held[b] = !held[b];
          if (held[b])
            run_left[b] = ($urandom_range(0, 9) < 2) ? 1 : $urandom_range(2, run_max);
          else
            run_left[b] = $urandom_range(1, 5);
        end
        run_left[b]--;
        mask[b] = held[b];
      end
      if ($urandom_range(0, 99) < NoisePct)
        send_levels(LevelsW'($urandom_range(0, (1 << LevelsW) - 1)));
      else
        press(mask);
    end
  endtask

  // Receiver: random stalls, a stall-free stretch, and one long hold-off.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        for (int k = 0; k < HoldOffCycles; k++) begin
          m_axis_tready <= 1'b0;
          @(negedge clk);
        end
        hold_req = 1'b0;
      end
      m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // Watchdog on cycles in which no channel moves anything.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb failed");
    $finish;
  end

  // Main stimulus sequence and verdict.
  initial begin
    logic [HoldW-1:0]   lp;
    logic [LevelsW-1:0] act;
    logic [7:0]         md;
    logic [31:0]        sid;
    logic [31:0]        lid;

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset configuration leaves every button inactive.
    send_levels('0);
    send_levels('1);
    drain();

    // Directed: release, press, long and inactive modes side by side.
    configure(16'd2, 4'h5, {MODE_INACTIVE, MODE_LONG, MODE_PRESS, MODE_RELEASE},
              32'h44332211, 32'hA4A3A2A1);
    foreach (DirectedMasks[k]) press(DirectedMasks[k]);
    drain();

    // Random phases; button states carry over so modes change mid-press.
    for (int p = 0; p < RandomPhases; p++) begin
      lp  = (p == 0) ? 16'd0 : (p == 1) ? 16'd1 :
            (p == 7) ? 16'($urandom_range(13, 30)) : 16'($urandom_range(2, 12));
      act = (p == 2) ? 4'hF : (p == 3) ? 4'h0 : LevelsW'($urandom_range(0, 15));
      md  = (p == 2) ? 8'h00 : (p == 3) ? 8'hAA : (p == 4) ? 8'h55 :
            8'($urandom_range(0, 255));
      sid = (p == 2) ? 32'hFFFFFFFF : (p == 3) ? 32'h0 : random_ids();
      lid = (p == 2) ? 32'hFFFFFFFF : (p == 3) ? 32'h0 : random_ids();
      configure(lp, act, md, sid, lid);
      no_idle = (p == 5);
      random_phase(PhaseItems, int'(lp), (p == 4) ? 20 : -1, (p == 2) ? 90 : -1);
      no_idle = 1'b0;
      drain();
    end

    // Longest threshold: one long-press button held well short of it, so the
    // release reports the short event.
    configure(16'hFFFF, 4'h1, {MODE_INACTIVE, MODE_INACTIVE, MODE_INACTIVE, MODE_LONG},
              random_ids() | 32'h1, random_ids() | 32'h1);
    no_idle = 1'b1;
    repeat (3) press(4'h0);
    repeat (LongHoldTicks) press(4'h1);
    repeat (2) press(4'h0);
    no_idle = 1'b0;
    drain();

    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
